@@ hdl/nested_circular_list_cursor_engine_core_macros.svh @@
// Assertion macros shared by the list engine top level.
// No dependencies; included by files that carry assertions.
`ifndef NESTED_CIRCULAR_LIST_CURSOR_ENGINE_CORE_MACROS_SVH
`define NESTED_CIRCULAR_LIST_CURSOR_ENGINE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define NCL_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define NCL_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ hdl/ncl_pkg.sv @@
// Package for the nested circular list engine: sizes, codes and shared types.
// No dependencies.
package ncl_pkg;
    localparam int MaxLists = 16;
    localparam int MaxItems = 64;
    localparam int TagBits  = 32;
    localparam int LW = $clog2(MaxLists);
    localparam int IW = $clog2(MaxItems);
    localparam int LCW = $clog2(MaxLists + 1);
    localparam int ICW = $clog2(MaxItems + 1);

    typedef enum logic [3:0] {
        REQ_NEW_LIST  = 4'd0, REQ_DEL_LIST  = 4'd1, REQ_NEXT_LIST = 4'd2,
        REQ_PREV_LIST = 4'd3, REQ_OPEN      = 4'd4, REQ_NEW_ITEM  = 4'd5,
        REQ_DEL_ITEM  = 4'd6, REQ_NEXT_ITEM = 4'd7, REQ_PREV_ITEM = 4'd8,
        REQ_WALK_LIST = 4'd9, REQ_WALK_ITEM = 4'd10
    } t_req;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NO_LIST = 3'd1, ST_EMPTY = 3'd2, ST_FULL = 3'd3, ST_UNKNOWN = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_NL_LINK, S_NI_LINK, S_NI_LINK2,
        S_DL_FREE, S_DL_FREE_RD, S_DL_UNLINK,
        S_LMOVE_RD, S_SYNC, S_ITAG,
        S_DI_LINK, S_DI_UNLINK,
        S_IMOVE_SET,
        S_WL_EMIT, S_WI_HEAD, S_WI_RD, S_WI_EMIT,
        S_REPLY, S_OUT_WAIT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        t_state     op;       // controller state, decoded by the datapath
        logic       ld_req;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic lc_valid;
        logic ic_valid;
        logic list_free_any;
        logic item_free_any;
        logic items_zero;      // current list has no items
        logic walk_done;       // walk counter at final node
        logic free_done;       // item free loop finished
        logic list_empty;      // list ring empty
    } t_stat;
endpackage

@@ hdl/ncl_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module ncl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write and registered read at one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ hdl/ncl_ctrl.sv @@
// Controller state machine of the list engine.
// Depends on ncl_pkg.
module ncl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [3:0]     i_req,
    input  logic           i_out_ready,
    input  ncl_pkg::t_stat i_stat,
    output ncl_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic [2:0]     o_status,
    output logic           o_last,
    output logic           o_emit
);
    import ncl_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [3:0] r_req, n_req;
    logic [2:0] r_st, n_st;
    logic r_last, n_last, r_emit, n_emit;
    logic ld_req;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_req   <= '0;
            r_st    <= '0;
            r_last  <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_req   <= n_req;
            r_st    <= n_st;
            r_last  <= n_last;
            r_emit  <= n_emit;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_req = r_req;
        n_st = r_st;
        n_last = r_last;
        n_emit = r_emit;
        o_in_ready = 1'b0;
        ld_req = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    ld_req = 1'b1;
                    n_req = i_req;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_st = ST_OK;
                n_last = 1'b1;
                n_emit = 1'b0;
                n_state = S_REPLY;
                if (r_req > 4'(REQ_WALK_ITEM)) begin
                    n_st = ST_UNKNOWN;
                end else if (r_req == REQ_WALK_LIST) begin
                    if (i_stat.list_empty) n_st = ST_EMPTY;
                    else n_state = S_WL_EMIT;
                end else if (r_req != REQ_NEW_LIST && !i_stat.lc_valid) begin
                    n_st = ST_NO_LIST;
                end else begin
                    unique case (r_req)
                        REQ_NEW_LIST: begin
                            if (!i_stat.list_free_any) n_st = ST_FULL;
                            else n_state = S_NL_LINK;
                        end
                        REQ_DEL_LIST: n_state = i_stat.items_zero ? S_DL_UNLINK : S_DL_FREE;
                        REQ_NEXT_LIST, REQ_PREV_LIST: n_state = S_LMOVE_RD;
                        REQ_OPEN: n_state = S_SYNC;
                        REQ_NEW_ITEM: begin
                            if (!i_stat.item_free_any) n_st = ST_FULL;
                            else n_state = S_NI_LINK;
                        end
                        REQ_DEL_ITEM: begin
                            if (i_stat.items_zero || !i_stat.ic_valid) n_st = ST_EMPTY;
                            else n_state = S_DI_LINK;
                        end
                        REQ_NEXT_ITEM, REQ_PREV_ITEM: begin
                            if (!i_stat.ic_valid) n_st = ST_EMPTY;
                            else n_state = S_IMOVE_SET;
                        end
                        default: begin
                            if (i_stat.items_zero) n_st = ST_EMPTY;
                            else n_state = S_WI_HEAD;
                        end
                    endcase
                end
            end
            S_NL_LINK:    n_state = S_SYNC;
            S_NI_LINK:    n_state = S_NI_LINK2;
            S_NI_LINK2:   n_state = S_REPLY;
            S_DL_FREE:    n_state = S_DL_FREE_RD;
            S_DL_FREE_RD: n_state = i_stat.free_done ? S_DL_UNLINK : S_DL_FREE;
            S_DL_UNLINK:  n_state = S_SYNC;
            S_LMOVE_RD:   n_state = S_SYNC;
            S_SYNC:       n_state = S_ITAG;
            S_ITAG:       n_state = S_REPLY;
            S_DI_LINK:    n_state = S_DI_UNLINK;
            S_DI_UNLINK:  n_state = S_REPLY;
            S_IMOVE_SET:  n_state = S_ITAG;
            S_WL_EMIT: begin
                n_last = i_stat.walk_done;
                n_emit = 1'b1;
                n_ret = i_stat.walk_done ? S_IDLE : S_WL_EMIT;
                n_state = S_OUT_WAIT;
            end
            S_WI_HEAD:    n_state = S_WI_RD;
            S_WI_RD:      n_state = S_WI_EMIT;
            S_WI_EMIT: begin
                n_last = i_stat.walk_done;
                n_emit = 1'b1;
                n_ret = i_stat.walk_done ? S_IDLE : S_WI_RD;
                n_state = S_OUT_WAIT;
            end
            S_REPLY: begin
                n_ret = S_IDLE;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_out_ready) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd       = '{op: r_state, ld_req: ld_req};
    assign o_out_valid = (r_state == S_OUT_WAIT);
    assign o_status    = r_st;
    assign o_last      = r_last;
    assign o_emit      = r_emit;
endmodule

@@ hdl/ncl_dpath.sv @@
// Datapath of the list engine: link memories, free maps, cursors, walk pointer.
// Depends on ncl_pkg and ncl_ram.
module ncl_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ncl_pkg::t_cmd            i_cmd,
    input  logic [3:0]               i_req,
    input  logic [31:0]              i_tag,
    output ncl_pkg::t_stat           o_stat,
    output logic [31:0]              o_item_tag,
    output logic                     o_item_cur,
    output logic [ncl_pkg::LCW-1:0]  o_list_count,
    output logic [ncl_pkg::ICW-1:0]  o_item_count,
    output logic [31:0]              o_cur_list_tag,
    output logic [31:0]              o_cur_item_tag,
    output logic                     o_has_list,
    output logic                     o_has_item
);
    import ncl_pkg::*;

    t_state op;
    logic [3:0] r_req;
    logic [TagBits-1:0] r_tag;

    // List side: small arrays held in flip-flops, read at cursor-driven places
    logic [LW-1:0] r_lnext [MaxLists];
    logic [LW-1:0] r_lprev [MaxLists];
    logic [TagBits-1:0] r_lname [MaxLists];
    logic [IW-1:0] r_ltail [MaxLists];
    logic [ICW-1:0] r_ltot [MaxLists];
    logic [MaxLists-1:0] r_lfree;
    logic [LW-1:0] r_ltail_ring;
    logic [LCW-1:0] r_lcnt;
    logic r_lcv;
    logic [LW-1:0] r_lc;

    // Item side: link and name memories
    logic [MaxItems-1:0] r_ifree;
    logic r_icv;
    logic [IW-1:0] r_ic;
    logic [TagBits-1:0] r_ic_tag;

    logic [IW-1:0] nl_addr, pl_addr, nm_addr;
    logic nl_we, pl_we, nm_we;
    logic [IW-1:0] nl_wd, pl_wd, nl_rd, pl_rd;
    logic [TagBits-1:0] nm_wd, nm_rd;

    logic [IW-1:0] r_p;           // walk / free pointer
    logic [ICW-1:0] r_k;          // loop count
    logic [IW-1:0] r_a, r_b;      // neighbours saved for unlink
    logic [LW-1:0] r_lp;          // list walk pointer

    logic [LW-1:0] lslot;
    logic [IW-1:0] islot;
    logic [LW-1:0] ltail_c, lhead_c;

    logic [TagBits-1:0] r_otag;
    logic r_ocur;

    assign op = i_cmd.op;

    ncl_ram #(.Width(IW), .Depth(MaxItems)) u_inext (
        .i_clk(i_clk), .i_we(nl_we), .i_addr(nl_addr), .i_wdata(nl_wd), .o_rdata(nl_rd));
    ncl_ram #(.Width(IW), .Depth(MaxItems)) u_iprev (
        .i_clk(i_clk), .i_we(pl_we), .i_addr(pl_addr), .i_wdata(pl_wd), .o_rdata(pl_rd));
    ncl_ram #(.Width(TagBits), .Depth(MaxItems)) u_iname (
        .i_clk(i_clk), .i_we(nm_we), .i_addr(nm_addr), .i_wdata(nm_wd), .o_rdata(nm_rd));

    // Lowest free slot of each pool
    always_comb begin
        lslot = '0;
        for (int i = MaxLists - 1; i >= 0; i--) begin
            if (r_lfree[i]) lslot = LW'(i);
        end
        islot = '0;
        for (int i = MaxItems - 1; i >= 0; i--) begin
            if (r_ifree[i]) islot = IW'(i);
        end
    end

    assign ltail_c = r_ltail_ring;
    assign lhead_c = r_lnext[r_ltail_ring];

    // Item memory port control; read data is registered and lands in the cycle after the address
    always_comb begin
        nl_we = 1'b0; pl_we = 1'b0; nm_we = 1'b0;
        nl_addr = r_p; pl_addr = r_p; nm_addr = r_p;
        nl_wd = '0; pl_wd = '0; nm_wd = r_tag;
        unique case (op)
            S_DISPATCH: begin
                // Tail's next (head) for insert and walk, else the cursor's links
                if (r_req == REQ_NEW_ITEM || r_req == REQ_WALK_ITEM) begin
                    nl_addr = r_ltail[r_lc];
                end else begin
                    nl_addr = r_ic; pl_addr = r_ic;
                end
            end
            S_NI_LINK: begin
                nm_we = 1'b1; nm_addr = islot;
                nl_we = 1'b1; pl_we = 1'b1;
                if (r_ltot[r_lc] == '0) begin
                    nl_addr = islot; nl_wd = islot;
                    pl_addr = islot; pl_wd = islot;
                end else begin
                    // new.next = head, head.prev = new
                    nl_addr = islot; nl_wd = nl_rd;
                    pl_addr = nl_rd; pl_wd = islot;
                end
            end
            S_NI_LINK2: begin
                // tail.next = new, new.prev = tail
                if (r_ltot[r_lc] != '0) begin
                    nl_we = 1'b1; nl_addr = r_ltail[r_lc]; nl_wd = islot;
                    pl_we = 1'b1; pl_addr = islot; pl_wd = r_ltail[r_lc];
                end
            end
            S_DI_LINK: begin
                // prev.next = next, next.prev = prev; fetch the next item's name
                if (r_ltot[r_lc] != ICW'(1)) begin
                    nl_we = 1'b1; nl_addr = pl_rd; nl_wd = nl_rd;
                    pl_we = 1'b1; pl_addr = nl_rd; pl_wd = pl_rd;
                end
                nm_addr = nl_rd;
            end
            S_IMOVE_SET: begin
                nm_addr = (r_req == REQ_NEXT_ITEM) ? nl_rd : pl_rd;
            end
            S_SYNC: begin
                nm_addr = r_ltail[r_lc];
            end
            default: ;
        endcase
    end

    // Sequential update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfree <= '1;
            r_ifree <= '1;
            r_ltail_ring <= '0;
            r_lcnt <= '0;
            r_lcv <= 1'b0;
            r_lc <= '0;
            r_icv <= 1'b0;
            r_ic <= '0;
        end else begin
            if (i_cmd.ld_req) begin
                r_req <= i_req;
                r_tag <= TagBits'(i_tag);
            end
            unique case (op)
                S_DISPATCH: begin
                    r_k <= '0;
                    r_lp <= lhead_c;
                    r_p <= r_ltail[r_lc];
                end
                S_NL_LINK: begin
                    r_lfree[lslot] <= 1'b0;
                    r_lname[lslot] <= r_tag;
                    r_ltail[lslot] <= '0;
                    r_ltot[lslot] <= '0;
                    if (r_lcnt == '0) begin
                        r_lnext[lslot] <= lslot;
                        r_lprev[lslot] <= lslot;
                    end else begin
                        r_lnext[lslot] <= lhead_c;
                        r_lprev[lhead_c] <= lslot;
                        r_lprev[lslot] <= ltail_c;
                        r_lnext[ltail_c] <= lslot;
                    end
                    r_ltail_ring <= lslot;
                    r_lcnt <= r_lcnt + LCW'(1);
                    r_lcv <= 1'b1;
                    r_lc <= lslot;
                end
                S_NI_LINK2: begin
                    r_ifree[islot] <= 1'b0;
                    r_ltail[r_lc] <= islot;
                    r_ltot[r_lc] <= r_ltot[r_lc] + ICW'(1);
                    r_icv <= 1'b1;
                    r_ic <= islot;
                    r_ic_tag <= r_tag;
                end
                S_DL_FREE: begin
                    r_ifree[r_p] <= 1'b1;
                    r_k <= r_k + ICW'(1);
                end
                S_DL_FREE_RD: begin
                    r_p <= nl_rd;
                end
                S_DL_UNLINK: begin
                    r_ltot[r_lc] <= '0;
                    r_lfree[r_lc] <= 1'b1;
                    r_lcnt <= r_lcnt - LCW'(1);
                    if (r_lcnt <= LCW'(1)) begin
                        r_lcv <= 1'b0;
                        r_lc <= '0;
                        r_ltail_ring <= '0;
                    end else begin
                        r_lnext[r_lprev[r_lc]] <= r_lnext[r_lc];
                        r_lprev[r_lnext[r_lc]] <= r_lprev[r_lc];
                        if (r_ltail_ring == r_lc) r_ltail_ring <= r_lprev[r_lc];
                        r_lc <= r_lnext[r_lc];
                    end
                end
                S_LMOVE_RD: begin
                    r_lc <= (r_req == REQ_NEXT_LIST) ? r_lnext[r_lc] : r_lprev[r_lc];
                end
                S_SYNC: begin
                    r_icv <= r_lcv && (r_ltot[r_lc] != '0);
                    r_ic <= (r_lcv && (r_ltot[r_lc] != '0)) ? r_ltail[r_lc] : '0;
                end
                S_ITAG: begin
                    // name read issued in the previous state lands here
                    r_ic_tag <= nm_rd;
                end
                S_DI_LINK: begin
                    r_a <= pl_rd;
                    r_b <= nl_rd;
                end
                S_DI_UNLINK: begin
                    r_ifree[r_ic] <= 1'b1;
                    r_ltot[r_lc] <= r_ltot[r_lc] - ICW'(1);
                    r_ic_tag <= nm_rd;
                    if (r_ltot[r_lc] == ICW'(1)) begin
                        r_ltail[r_lc] <= '0;
                        r_icv <= 1'b0;
                        r_ic <= '0;
                    end else begin
                        if (r_ltail[r_lc] == r_ic) r_ltail[r_lc] <= r_a;
                        r_ic <= r_b;
                    end
                end
                S_IMOVE_SET: begin
                    r_ic <= (r_req == REQ_NEXT_ITEM) ? nl_rd : pl_rd;
                end
                S_WI_HEAD: begin
                    r_p <= nl_rd;
                end
                S_WI_EMIT: begin
                    r_p <= nl_rd;
                    r_k <= r_k + ICW'(1);
                end
                S_WL_EMIT: begin
                    r_lp <= r_lnext[r_lp];
                    r_k <= r_k + ICW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_stat.lc_valid = r_lcv;
    assign o_stat.ic_valid = r_icv;
    assign o_stat.list_free_any = |r_lfree;
    assign o_stat.item_free_any = |r_ifree;
    assign o_stat.items_zero = (r_ltot[r_lc] == '0);
    assign o_stat.walk_done = (op == S_WL_EMIT) ? ((r_k + ICW'(1)) == ICW'(r_lcnt))
                                                : ((r_k + ICW'(1)) == r_ltot[r_lc]);
    assign o_stat.free_done = (r_k == r_ltot[r_lc]);
    assign o_stat.list_empty = (r_lcnt == '0);

    // Result fields of a walk
    always_ff @(posedge i_clk) begin
        if (op == S_DISPATCH) begin
            r_otag <= '0; r_ocur <= 1'b0;
        end else if (op == S_WL_EMIT) begin
            r_otag <= r_lname[r_lp];
            r_ocur <= r_lcv && (r_lc == r_lp);
        end else if (op == S_WI_EMIT) begin
            r_otag <= nm_rd;
            r_ocur <= r_icv && (r_ic == r_p);
        end
    end

    assign o_item_tag     = 32'(r_otag);
    assign o_item_cur     = r_ocur;
    assign o_list_count   = r_lcnt;
    assign o_item_count   = r_lcv ? r_ltot[r_lc] : '0;
    assign o_cur_list_tag = r_lcv ? 32'(r_lname[r_lc]) : '0;
    assign o_cur_item_tag = r_icv ? 32'(r_ic_tag) : '0;
    assign o_has_list     = r_lcv;
    assign o_has_item     = r_icv;
endmodule

@@ hdl/nested_circular_list_cursor_engine_core.sv @@
// Nested circular list engine: a ring of up to 16 lists, each with a ring of items
// drawn from a shared pool of 64. One request is taken at a time and its results go
// out before the next is taken. The item link memories are single-port with
// registered read. Every result carries the cursor state after the request; tlast
// ends the request.
module nested_circular_list_cursor_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [39:0]   s_axis_tdata,   // [3:0] req_type, [35:4] name_tag
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // status, item_tag, item_is_current, list_count,
                                          // item_count, current_list_tag,
                                          // current_item_tag, has_current_list,
                                          // has_current_item
    output logic          m_axis_tlast
);
    import ncl_pkg::*;
    `include "nested_circular_list_cursor_engine_core_macros.svh"

    t_cmd cmd;
    t_stat stat;
    logic [2:0] status;
    logic last, emit;
    logic [31:0] item_tag, cl_tag, ci_tag;
    logic item_cur, has_l, has_i;
    logic [LCW-1:0] lcount;
    logic [ICW-1:0] icount;

    ncl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_req(s_axis_tdata[3:0]), .i_out_ready(m_axis_tready), .i_stat(stat),
        .o_cmd(cmd), .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_status(status), .o_last(last), .o_emit(emit));

    ncl_dpath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(s_axis_tdata[3:0]),
        .i_tag(s_axis_tdata[35:4]), .o_stat(stat), .o_item_tag(item_tag),
        .o_item_cur(item_cur), .o_list_count(lcount), .o_item_count(icount),
        .o_cur_list_tag(cl_tag), .o_cur_item_tag(ci_tag), .o_has_list(has_l),
        .o_has_item(has_i));

    assign m_axis_tdata = {6'd0, has_i, has_l, ci_tag, cl_tag, 7'(icount), 5'(lcount),
                           item_cur & emit, item_tag & {32{emit}}, status};
    assign m_axis_tlast = last;

    `NCL_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "input taken while a result waits")
    `NCL_ASSERT_IMP(a_cursor_item, i_clk, i_rst_n, m_axis_tvalid && has_i, has_l,
        "item cursor without list cursor")
    `NCL_ASSERT_NXT(a_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second item taken straight after the first")
endmodule

@@ test/nested_circular_list_cursor_engine_core_tb.sv @@
// Testbench for the nested circular list engine: random and directed requests,
// checked item by item against a cursor/ring predictor held in a scoreboard class.
// Depends on ncl_pkg and nested_circular_list_cursor_engine_core.
module nested_circular_list_cursor_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ncl_pkg::*;

    localparam logic [3:0] REQ_BAD_LO = 4'(REQ_WALK_ITEM) + 4'd1;
    localparam logic [3:0] REQ_BAD_HI = 4'hF;
    localparam int CycleLimit = 2000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] item_tag;
        logic        is_cur;
        logic        last;
        logic [4:0]  list_cnt;
        logic [6:0]  item_cnt;
        logic [31:0] cur_list_tag;
        logic [31:0] cur_item_tag;
        logic        has_list;
        logic        has_item;
    } t_reply;

    // Ring store predictor and queue of expected replies
    class ring_scoreboard;
        logic [3:0]  lnext[MaxLists], lprev[MaxLists];
        logic [31:0] lname[MaxLists];
        logic [5:0]  ltail[MaxLists];
        logic [6:0]  ltotal[MaxLists];
        logic [15:0] lfree;
        logic [3:0]  ring_tail;
        logic [4:0]  ring_total;
        bit          lc_ok;
        logic [3:0]  lc;
        logic [5:0]  inext[MaxItems], iprev[MaxItems];
        logic [31:0] iname[MaxItems];
        logic [63:0] ifree;
        bit          ic_ok;
        logic [5:0]  ic;
        t_reply      pending[$];
        int          errors;

        function new();
            lfree = '1; ifree = '1; ring_tail = 0; ring_total = 0;
            lc_ok = 0; lc = 0; ic_ok = 0; ic = 0; errors = 0;
        endfunction

        function void follow_list();
            ic_ok = lc_ok && ltotal[lc] != 0;
            ic = ic_ok ? ltail[lc] : '0;
        endfunction

        function void emit(t_status st, logic [31:0] tag, bit cur, bit fin);
            t_reply r;
            r.status = st; r.item_tag = tag; r.is_cur = cur; r.last = fin;
            r.list_cnt = ring_total;
            r.item_cnt = lc_ok ? ltotal[lc] : '0;
            r.cur_list_tag = lc_ok ? lname[lc] : '0;
            r.cur_item_tag = ic_ok ? iname[ic] : '0;
            r.has_list = lc_ok; r.has_item = ic_ok;
            pending.push_back(r);
        endfunction

        // Work out the replies for one accepted request
        function void note_request(logic [3:0] req, logic [31:0] tag);
            t_status st;
            int n, cnt;
            logic [5:0] p, nx, t, h;
            logic [3:0] lp, lnx, lt, lh, r;
            st = ST_OK;
            if (req > 4'(REQ_WALK_ITEM)) begin
                emit(ST_UNKNOWN, 0, 0, 1);
                return;
            end
            if (req == 4'(REQ_WALK_LIST)) begin
                if (ring_total == 0) begin
                    emit(ST_EMPTY, 0, 0, 1);
                    return;
                end
                lp = lnext[ring_tail];
                for (int k = 0; k < ring_total; k++) begin
                    emit(ST_OK, lname[lp], lc_ok && lc == lp, k + 1 == ring_total);
                    lp = lnext[lp];
                end
                return;
            end
            if (req != 4'(REQ_NEW_LIST) && !lc_ok) begin
                emit(ST_NO_LIST, 0, 0, 1);
                return;
            end
            r = lc;
            case (req)
                REQ_NEW_LIST: begin
                    n = -1;
                    for (int i = 0; i < MaxLists; i++)
                        if (n < 0 && lfree[i]) n = i;
                    if (n < 0) begin
                        st = ST_FULL;
                    end else begin
                        lfree[n] = 0;
                        lname[n] = tag; ltail[n] = 0; ltotal[n] = 0;
                        if (ring_total == 0) begin
                            lnext[n] = 4'(n); lprev[n] = 4'(n);
                        end else begin
                            lt = ring_tail; lh = lnext[lt];
                            lnext[n] = lh; lprev[lh] = 4'(n);
                            lprev[n] = lt; lnext[lt] = 4'(n);
                        end
                        ring_tail = 4'(n);
                        ring_total++;
                        lc_ok = 1; lc = 4'(n);
                        follow_list();
                    end
                end
                REQ_DEL_LIST: begin
                    cnt = ltotal[r];
                    p = ltail[r];
                    for (int i = 0; i < cnt; i++) begin
                        ifree[p] = 1;
                        p = inext[p];
                    end
                    ltotal[r] = 0;
                    if (ring_total <= 1) begin
                        lc_ok = 0; lc = 0; ring_tail = 0;
                    end else begin
                        lp = lprev[r]; lnx = lnext[r];
                        lnext[lp] = lnx; lprev[lnx] = lp;
                        if (ring_tail == r) ring_tail = lp;
                        lc = lnx;
                    end
                    lfree[r] = 1;
                    ring_total--;
                    follow_list();
                end
                REQ_NEXT_LIST: begin
                    lc = lnext[r];
                    follow_list();
                end
                REQ_PREV_LIST: begin
                    lc = lprev[r];
                    follow_list();
                end
                REQ_OPEN: follow_list();
                REQ_NEW_ITEM: begin
                    n = -1;
                    for (int i = 0; i < MaxItems; i++)
                        if (n < 0 && ifree[i]) n = i;
                    if (n < 0) begin
                        st = ST_FULL;
                    end else begin
                        ifree[n] = 0;
                        iname[n] = tag;
                        if (ltotal[r] == 0) begin
                            inext[n] = 6'(n); iprev[n] = 6'(n);
                        end else begin
                            t = ltail[r]; h = inext[t];
                            inext[n] = h; iprev[h] = 6'(n);
                            iprev[n] = t; inext[t] = 6'(n);
                        end
                        ltail[r] = 6'(n);
                        ltotal[r]++;
                        ic_ok = 1; ic = 6'(n);
                    end
                end
                REQ_DEL_ITEM: begin
                    if (ltotal[r] == 0 || !ic_ok) begin
                        st = ST_EMPTY;
                    end else begin
                        t = ic;
                        if (ltotal[r] == 1) begin
                            ltail[r] = 0; ic_ok = 0; ic = 0;
                        end else begin
                            p = iprev[t]; nx = inext[t];
                            inext[p] = nx; iprev[nx] = p;
                            if (ltail[r] == t) ltail[r] = p;
                            ic = nx;
                        end
                        ifree[t] = 1;
                        ltotal[r]--;
                    end
                end
                REQ_NEXT_ITEM: begin
                    if (!ic_ok) st = ST_EMPTY;
                    else ic = inext[ic];
                end
                REQ_PREV_ITEM: begin
                    if (!ic_ok) st = ST_EMPTY;
                    else ic = iprev[ic];
                end
                default: begin
                    cnt = ltotal[r];
                    if (cnt == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        p = inext[ltail[r]];
                        for (int k = 0; k < cnt; k++) begin
                            emit(ST_OK, iname[p], ic_ok && ic == p, k + 1 == cnt);
                            p = inext[p];
                        end
                        return;
                    end
                end
            endcase
            emit(st, 0, 0, 1);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        endfunction

        // Compare one accepted reply with the oldest expectation
        function void check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                report("unexpected reply", got.status, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.item_tag !== want.item_tag) report("item_tag", got.item_tag, want.item_tag);
            if (got.is_cur !== want.is_cur) report("item_is_current", got.is_cur, want.is_cur);
            if (got.last !== want.last) report("tlast", got.last, want.last);
            if (got.list_cnt !== want.list_cnt) report("list_count", got.list_cnt, want.list_cnt);
            if (got.item_cnt !== want.item_cnt) report("item_count", got.item_cnt, want.item_cnt);
            if (got.cur_list_tag !== want.cur_list_tag)
                report("current_list_tag", got.cur_list_tag, want.cur_list_tag);
            if (got.cur_item_tag !== want.cur_item_tag)
                report("current_item_tag", got.cur_item_tag, want.cur_item_tag);
            if (got.has_list !== want.has_list)
                report("has_current_list", got.has_list, want.has_list);
            if (got.has_item !== want.has_item)
                report("has_current_item", got.has_item, want.has_item);
        endfunction
    endclass

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [39:0]   s_axis_tdata = '0;   // [3:0] req_type, [35:4] name_tag
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [119:0]  m_axis_tdata;        // status, item_tag, item_is_current, list_count,
                                        // item_count, current_list_tag, current_item_tag,
                                        // has_current_list, has_current_item
    logic          m_axis_tlast;

    ring_scoreboard sb = new();
    int  tx_idle_pct = 9;
    int  rx_idle_pct = 76;
    bit  hold_go = 0;
    int  hold_left = 400;
    int  cycles = 0;

    nested_circular_list_cursor_engine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("nested_circular_list_cursor_engine_core_tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once requested
    always @(posedge i_clk) begin
        if (hold_go && hold_left != 0) begin
            m_axis_tready <= 0;
            hold_left <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_reply unpack_reply(logic [119:0] d, logic fin);
        t_reply r;
        r.status = d[2:0];
        r.item_tag = d[34:3];
        r.is_cur = d[35];
        r.last = fin;
        r.list_cnt = d[40:36];
        r.item_cnt = d[47:41];
        r.cur_list_tag = d[79:48];
        r.cur_item_tag = d[111:80];
        r.has_list = d[112];
        r.has_item = d[113];
        return r;
    endfunction

    // Reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(unpack_reply(m_axis_tdata, m_axis_tlast));
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(logic [3:0] req, logic [31:0] tag);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'b0, tag, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(req, tag);
    endtask

    // Weighted request choice; grow favours inserts, otherwise deletes
    function automatic logic [3:0] pick_request(bit grow);
        int w;
        w = $urandom_range(99);
        if (w < 3) return 4'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
        if (grow) begin
            if (w < 15) return REQ_NEW_LIST;
            if (w < 55) return REQ_NEW_ITEM;
        end else begin
            if (w < 10) return REQ_DEL_LIST;
            if (w < 40) return REQ_DEL_ITEM;
            if (w < 45) return REQ_NEW_ITEM;
            if (w < 48) return REQ_NEW_LIST;
        end
        if (w < 62) return REQ_NEXT_LIST;
        if (w < 68) return REQ_PREV_LIST;
        if (w < 72) return REQ_OPEN;
        if (w < 80) return REQ_NEXT_ITEM;
        if (w < 86) return REQ_PREV_ITEM;
        if (w < 92) return REQ_WALK_LIST;
        return REQ_WALK_ITEM;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty store, unknown codes, tag extremes, every request
        send_request(REQ_WALK_LIST, 0);
        send_request(REQ_NEXT_LIST, 0);
        send_request(REQ_WALK_ITEM, 0);
        send_request(REQ_BAD_LO, 32'hFFFF_FFFF);
        send_request(REQ_BAD_HI, 0);
        send_request(REQ_NEW_LIST, 32'h0);
        send_request(REQ_WALK_ITEM, 0);
        send_request(REQ_DEL_ITEM, 0);
        send_request(REQ_NEXT_ITEM, 0);
        send_request(REQ_PREV_ITEM, 0);
        send_request(REQ_NEW_LIST, 32'hFFFF_FFFF);
        send_request(REQ_NEW_ITEM, 32'hFFFF_FFFF);
        send_request(REQ_NEW_ITEM, 32'h0);
        send_request(REQ_NEW_ITEM, 32'hA5A5_5A5A);
        send_request(REQ_WALK_ITEM, 0);
        send_request(REQ_NEXT_ITEM, 0);
        send_request(REQ_PREV_ITEM, 0);
        send_request(REQ_DEL_ITEM, 0);
        send_request(REQ_PREV_LIST, 0);
        send_request(REQ_OPEN, 0);
        send_request(REQ_NEXT_LIST, 0);
        send_request(REQ_WALK_LIST, 0);
        send_request(REQ_DEL_LIST, 0);
        send_request(REQ_DEL_LIST, 0);
        send_request(REQ_OPEN, 0);

        // Random: three idling regimes, grow and shrink stretches within each
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 76 : 0;
            rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 9 : 0;
            for (int n = 0; n < 152; n++) begin
                if (ph == 2 && n == 20) hold_go = 1;
                send_request(pick_request(((n / 80) % 2) == 0 || n % 80 < 50),
                             $urandom());
            end
        end
        s_axis_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("nested_circular_list_cursor_engine_core_tb passed");
        else
            $display("nested_circular_list_cursor_engine_core_tb failed");
        $finish;
    end
endmodule
